// ===== hdl/nd_pic_pkg.sv =====
// ----------------------------------------------------------------------------
// nd_pic_pkg
// Shared constants, register map and types of the N-dimensional pixel index
// converter.
// ----------------------------------------------------------------------------
package nd_pic_pkg;

    localparam int NUM_LEN_REGS       = 4;
    localparam int DEF_MAX_AXES       = 4;
    localparam int DEF_AXIS_BITS      = 16;
    localparam int DEF_INDEX_BITS     = 32;
    localparam int CFG_ADDR_BITS      = 5;
    localparam int APB_DATA_BITS      = 32;
    localparam int COUNT_BITS         = 3;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int LIN_DEPTH          = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_RESET = 3'd2;

    typedef enum logic [2:0] {
        REG_AXIS_COUNT = 3'd0,
        REG_AXIS_LEN_0 = 3'd1,
        REG_AXIS_LEN_1 = 3'd2,
        REG_AXIS_LEN_2 = 3'd3,
        REG_AXIS_LEN_3 = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic                    ready;
        logic                    ovf;
        logic                    zero_len;
        logic [COUNT_BITS-1:0]   used_axes;
        logic [NUM_LEN_REGS-1:0] sat;
    } shape_status_t;

    typedef struct packed {
        logic func;
        logic idx_max;
    } req_meta_t;

endpackage

// ===== hdl/nd_pic_shape.sv =====
// ----------------------------------------------------------------------------
// nd_pic_shape
// Configuration registers behind the APB port and a sequencer that derives
// the axis strides and total element count, one multiply per cycle.
// ----------------------------------------------------------------------------
module nd_pic_shape
    import nd_pic_pkg::*;
#(
    parameter int LANES      = DEF_MAX_AXES,
    parameter int AXIS_BITS  = DEF_AXIS_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    output logic [AXIS_BITS-1:0]     len_o    [LANES],
    output logic [INDEX_BITS-1:0]    stride_o [LANES],
    output logic [INDEX_BITS-1:0]    total_o,
    output shape_status_t            status_o
);

    localparam int STEP_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int PW     = INDEX_BITS + AXIS_BITS;

    typedef enum logic [1:0] {
        SHP_IDLE = 2'b01,
        SHP_CALC = 2'b10
    } shp_state_t;

    shp_state_t              state_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [INDEX_BITS-1:0]   acc_reg;
    logic                    ovf_reg;
    logic [COUNT_BITS-1:0]   count_reg;
    logic [AXIS_BITS-1:0]    len_reg    [NUM_LEN_REGS];
    logic [INDEX_BITS-1:0]   stride_reg [LANES];
    logic [LANES-1:0]        sat_reg;
    logic [AXIS_BITS-1:0]    lane_len   [LANES];
    logic [COUNT_BITS-1:0]   used_axes;
    logic                    zero_len;
    logic                    wr_en;
    logic                    step_used;
    logic                    step_last;
    logic [PW-1:0]           prod;
    logic                    prod_hi;
    reg_index_t              reg_sel;

    for (genvar d = 0; d < LANES; d++) begin : g_lane
        assign lane_len[d] = len_reg[d];
        assign len_o[d]    = len_reg[d];
        assign stride_o[d] = stride_reg[d];
    end

    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign reg_sel = reg_index_t'(paddr[CFG_ADDR_BITS-1:2]);

    always_comb begin
        if (count_reg == '0) begin
            used_axes = COUNT_BITS'(1);
        end else if (count_reg > COUNT_BITS'(LANES)) begin
            used_axes = COUNT_BITS'(LANES);
        end else begin
            used_axes = count_reg;
        end
    end

    always_comb begin
        zero_len = 1'b0;
        for (int d = 0; d < LANES; d++) begin
            if (COUNT_BITS'(d) < used_axes && lane_len[d] == '0) begin
                zero_len = 1'b1;
            end
        end
    end

    assign step_used = 32'(step_reg) < 32'(used_axes);
    assign step_last = step_reg == STEP_W'(LANES - 1);
    assign prod      = PW'(acc_reg) * PW'(lane_len[step_reg]);
    assign prod_hi   = prod[PW-1:INDEX_BITS] != '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SHP_CALC;
            step_reg  <= '0;
            acc_reg   <= INDEX_BITS'(1);
            ovf_reg   <= 1'b0;
            count_reg <= COUNT_RESET;
            for (int d = 0; d < NUM_LEN_REGS; d++) begin
                len_reg[d] <= AXIS_BITS'(1);
            end
        end else if (wr_en) begin
            state_reg <= SHP_CALC;
            step_reg  <= '0;
            acc_reg   <= INDEX_BITS'(1);
            ovf_reg   <= 1'b0;
            case (reg_sel)
                REG_AXIS_COUNT: count_reg  <= pwdata[COUNT_BITS-1:0];
                REG_AXIS_LEN_0: len_reg[0] <= pwdata[AXIS_BITS-1:0];
                REG_AXIS_LEN_1: len_reg[1] <= pwdata[AXIS_BITS-1:0];
                REG_AXIS_LEN_2: len_reg[2] <= pwdata[AXIS_BITS-1:0];
                REG_AXIS_LEN_3: len_reg[3] <= pwdata[AXIS_BITS-1:0];
                default: ;
            endcase
        end else begin
            case (state_reg)
                SHP_CALC: begin
                    stride_reg[step_reg] <= acc_reg;
                    sat_reg[step_reg]    <= ovf_reg;
                    if (step_used) begin
                        acc_reg <= prod_hi ? '1 : prod[INDEX_BITS-1:0];
                        ovf_reg <= ovf_reg | prod_hi;
                    end
                    if (step_last) begin
                        state_reg <= SHP_IDLE;
                    end else begin
                        step_reg <= step_reg + STEP_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_AXIS_COUNT: prdata = APB_DATA_BITS'(count_reg);
            REG_AXIS_LEN_0: prdata = APB_DATA_BITS'(len_reg[0]);
            REG_AXIS_LEN_1: prdata = APB_DATA_BITS'(len_reg[1]);
            REG_AXIS_LEN_2: prdata = APB_DATA_BITS'(len_reg[2]);
            REG_AXIS_LEN_3: prdata = APB_DATA_BITS'(len_reg[3]);
            default:        prdata = '0;
        endcase
    end

    assign total_o            = acc_reg;
    assign status_o.ready     = state_reg == SHP_IDLE;
    assign status_o.ovf       = ovf_reg;
    assign status_o.zero_len  = zero_len;
    assign status_o.used_axes = used_axes;
    assign status_o.sat       = NUM_LEN_REGS'(sat_reg);

endmodule

// ===== hdl/nd_pic_linear.sv =====
// ----------------------------------------------------------------------------
// nd_pic_linear
// Three-stage coordinate-to-index path: per-axis multiply and bounds check,
// sum, then compare against the element count and select.
// ----------------------------------------------------------------------------
module nd_pic_linear
    import nd_pic_pkg::*;
#(
    parameter int LANES      = DEF_MAX_AXES,
    parameter int AXIS_BITS  = DEF_AXIS_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                   aclk,
    input  logic                   en,
    input  logic [COUNT_BITS-1:0]  dims_given,
    input  logic [AXIS_BITS-1:0]   coord    [LANES],
    input  logic [AXIS_BITS-1:0]   len      [LANES],
    input  logic [INDEX_BITS-1:0]  stride   [LANES],
    input  logic [INDEX_BITS-1:0]  total,
    input  shape_status_t          status,
    output logic [INDEX_BITS-1:0]  flat_o,
    output logic                   oob_o
);

    localparam int PW = INDEX_BITS + AXIS_BITS;
    localparam int SW = INDEX_BITS + 2;

    logic [COUNT_BITS-1:0] used_m;
    logic [INDEX_BITS-1:0] prod_reg [LANES];
    logic                  bad_reg;
    logic [SW-1:0]         sum_reg;
    logic                  bad2_reg;
    logic [INDEX_BITS-1:0] flat_reg;
    logic                  oob_reg;
    logic                  bad_next;
    logic [SW-1:0]         sum_next;
    logic [PW-1:0]         prod_full [LANES];

    assign used_m = (dims_given < status.used_axes) ? dims_given : status.used_axes;

    always_comb begin
        bad_next = 1'b0;
        for (int d = 0; d < LANES; d++) begin
            prod_full[d] = PW'(coord[d]) * PW'(stride[d]);
            if (COUNT_BITS'(d) < used_m && coord[d] >= len[d]) begin
                bad_next = 1'b1;
            end
        end
    end

    always_comb begin
        sum_next = '0;
        for (int d = 0; d < LANES; d++) begin
            sum_next = sum_next + SW'(prod_reg[d]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < LANES; d++) begin
                prod_reg[d] <= (COUNT_BITS'(d) < used_m) ? prod_full[d][INDEX_BITS-1:0] : '0;
            end
            bad_reg  <= bad_next;
            sum_reg  <= sum_next;
            bad2_reg <= bad_reg;
            if (status.ovf) begin
                flat_reg <= '1;
                oob_reg  <= 1'b1;
            end else if (bad2_reg || sum_reg >= SW'(total)) begin
                flat_reg <= total;
                oob_reg  <= 1'b1;
            end else begin
                flat_reg <= sum_reg[INDEX_BITS-1:0];
                oob_reg  <= 1'b0;
            end
        end
    end

    assign flat_o = flat_reg;
    assign oob_o  = oob_reg;

endmodule

// ===== hdl/nd_pic_divchain.sv =====
// ----------------------------------------------------------------------------
// nd_pic_divchain
// Pipelined restoring divider chain: the index is divided by each axis
// length in turn, a few quotient bits per stage; each remainder is the
// coordinate of that axis and each quotient feeds the next axis.
// ----------------------------------------------------------------------------
module nd_pic_divchain
    import nd_pic_pkg::*;
#(
    parameter int LANES      = DEF_MAX_AXES,
    parameter int AXIS_BITS  = DEF_AXIS_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [INDEX_BITS-1:0] dividend,
    input  logic [AXIS_BITS-1:0]  len   [LANES],
    output logic [AXIS_BITS-1:0]  coord [LANES]
);

    localparam int BPS   = DIV_BITS_PER_STAGE;
    localparam int SPA   = (INDEX_BITS + BPS - 1) / BPS;
    localparam int DEPTH = LANES * SPA;

    logic [AXIS_BITS-1:0]  r_reg [DEPTH];
    logic [INDEX_BITS-1:0] x_reg [DEPTH];
    logic [AXIS_BITS-1:0]  c_reg [DEPTH][LANES];

    for (genvar g = 0; g < DEPTH; g++) begin : g_stage
        localparam int AX = g / SPA;
        localparam int ST = g % SPA;

        logic [AXIS_BITS-1:0]  r_in;
        logic [INDEX_BITS-1:0] x_in;
        logic [AXIS_BITS-1:0]  c_in [LANES];
        logic [AXIS_BITS-1:0]  r_out;
        logic [INDEX_BITS-1:0] x_out;

        if (g == 0) begin : g_first
            assign r_in = '0;
            assign x_in = dividend;
            for (genvar l = 0; l < LANES; l++) begin : g_c
                assign c_in[l] = '0;
            end
        end else begin : g_next
            assign r_in = (ST == 0) ? '0 : r_reg[g-1];
            assign x_in = x_reg[g-1];
            for (genvar l = 0; l < LANES; l++) begin : g_c
                assign c_in[l] = c_reg[g-1][l];
            end
        end

        always_comb begin
            logic [AXIS_BITS:0] t;
            logic [AXIS_BITS:0] diff;
            logic               ge;
            t     = '0;
            diff  = '0;
            ge    = 1'b0;
            r_out = r_in;
            x_out = x_in;
            for (int i = 0; i < BPS; i++) begin
                if (ST * BPS + i < INDEX_BITS) begin
                    t     = {r_out, x_out[INDEX_BITS-1]};
                    diff  = t - {1'b0, len[AX]};
                    ge    = t >= {1'b0, len[AX]};
                    r_out = ge ? diff[AXIS_BITS-1:0] : t[AXIS_BITS-1:0];
                    x_out = {x_out[INDEX_BITS-2:0], ge};
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[g] <= r_out;
                x_reg[g] <= x_out;
                for (int l = 0; l < LANES; l++) begin
                    c_reg[g][l] <= (ST == SPA - 1 && l == AX) ? r_out : c_in[l];
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign coord[l] = c_reg[DEPTH-1][l];
    end

endmodule

// ===== hdl/nd_pixel_index_converter.sv =====
// ----------------------------------------------------------------------------
// nd_pixel_index_converter
// Converts an N-dimensional pixel coordinate to a flat row-major index
// (first axis fastest) and back, for a shape set over APB.
//
// Requests enter on the s_ channel and results leave on the m_ channel, both
// valid/ready. With s_func low the coordinates are linearized into
// m_flat_out; with s_func high s_flat_in is split into m_coord_out_*.
// m_out_of_bounds flags coordinates outside the shape, a shape whose element
// count exceeds the index range and, with s_func high, a zero-length axis.
// One request is taken per cycle while s_ready is high. The divider chain
// retires four quotient bits per stage for each axis in turn. After reset
// and after every register write the stride sequencer runs, one multiply
// per axis, with s_ready low.
// When the receiver holds m_ready low with a result pending, the whole
// pipeline holds and s_ready drops; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module nd_pixel_index_converter
    import nd_pic_pkg::*;
#(
    parameter int MAX_AXES   = DEF_MAX_AXES,
    parameter int AXIS_BITS  = DEF_AXIS_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_func,
    input  logic [COUNT_BITS-1:0]    s_dims_given,
    input  logic [AXIS_BITS-1:0]     s_coord_in_0,
    input  logic [AXIS_BITS-1:0]     s_coord_in_1,
    input  logic [AXIS_BITS-1:0]     s_coord_in_2,
    input  logic [AXIS_BITS-1:0]     s_coord_in_3,
    input  logic [INDEX_BITS-1:0]    s_flat_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [INDEX_BITS-1:0]    m_flat_out,
    output logic [AXIS_BITS-1:0]     m_coord_out_0,
    output logic [AXIS_BITS-1:0]     m_coord_out_1,
    output logic [AXIS_BITS-1:0]     m_coord_out_2,
    output logic [AXIS_BITS-1:0]     m_coord_out_3,
    output logic                     m_out_of_bounds
);

    localparam int LANES     = (MAX_AXES < NUM_LEN_REGS) ? MAX_AXES : NUM_LEN_REGS;
    localparam int DIV_DEPTH = LANES * ((INDEX_BITS + DIV_BITS_PER_STAGE - 1)
                                        / DIV_BITS_PER_STAGE);
    localparam int LIN_DELAY = DIV_DEPTH - LIN_DEPTH;

    shape_status_t         status;
    logic [AXIS_BITS-1:0]  len    [LANES];
    logic [INDEX_BITS-1:0] stride [LANES];
    logic [INDEX_BITS-1:0] total;
    logic [AXIS_BITS-1:0]  coord_all [NUM_LEN_REGS];
    logic [AXIS_BITS-1:0]  coord_lane [LANES];
    logic [AXIS_BITS-1:0]  div_coord [LANES];
    logic [INDEX_BITS-1:0] lin_flat;
    logic                  lin_oob;
    logic                  en;
    logic                  accept;

    logic                  vld_reg  [DIV_DEPTH];
    req_meta_t             meta_reg [DIV_DEPTH];
    logic [INDEX_BITS-1:0] lflat_reg [LIN_DELAY];
    logic                  loob_reg  [LIN_DELAY];

    logic                  m_valid_reg;
    logic [INDEX_BITS-1:0] m_flat_reg;
    logic [AXIS_BITS-1:0]  m_coord_reg  [NUM_LEN_REGS];
    logic                  m_oob_reg;
    logic [INDEX_BITS-1:0] flat_next;
    logic [AXIS_BITS-1:0]  coord_next   [NUM_LEN_REGS];
    logic                  oob_next;
    req_meta_t             meta_tail;

    assign coord_all[0] = s_coord_in_0;
    assign coord_all[1] = s_coord_in_1;
    assign coord_all[2] = s_coord_in_2;
    assign coord_all[3] = s_coord_in_3;

    for (genvar d = 0; d < LANES; d++) begin : g_lane
        assign coord_lane[d] = coord_all[d];
    end

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en && status.ready;
    assign accept  = s_valid && s_ready;

    nd_pic_shape #(
        .LANES      (LANES),
        .AXIS_BITS  (AXIS_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_shape (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .len_o    (len),
        .stride_o (stride),
        .total_o  (total),
        .status_o (status)
    );

    nd_pic_linear #(
        .LANES      (LANES),
        .AXIS_BITS  (AXIS_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_linear (
        .aclk       (aclk),
        .en         (en),
        .dims_given (s_dims_given),
        .coord      (coord_lane),
        .len        (len),
        .stride     (stride),
        .total      (total),
        .status     (status),
        .flat_o     (lin_flat),
        .oob_o      (lin_oob)
    );

    nd_pic_divchain #(
        .LANES      (LANES),
        .AXIS_BITS  (AXIS_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_divchain (
        .aclk     (aclk),
        .en       (en),
        .dividend (s_flat_in),
        .len      (len),
        .coord    (div_coord)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= accept;
            for (int i = 1; i < DIV_DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[DIV_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta_reg[0].func    <= s_func;
            meta_reg[0].idx_max <= s_flat_in == '1;
            for (int i = 1; i < DIV_DEPTH; i++) begin
                meta_reg[i] <= meta_reg[i-1];
            end
            lflat_reg[0] <= lin_flat;
            loob_reg[0]  <= lin_oob;
            for (int i = 1; i < LIN_DELAY; i++) begin
                lflat_reg[i] <= lflat_reg[i-1];
                loob_reg[i]  <= loob_reg[i-1];
            end
            m_flat_reg <= flat_next;
            m_oob_reg  <= oob_next;
            for (int d = 0; d < NUM_LEN_REGS; d++) begin
                m_coord_reg[d] <= coord_next[d];
            end
        end
    end

    assign meta_tail = meta_reg[DIV_DEPTH-1];

    always_comb begin
        for (int d = 0; d < NUM_LEN_REGS; d++) begin
            coord_next[d] = '0;
        end
        if (meta_tail.func) begin
            flat_next = '0;
            oob_next  = status.zero_len | status.ovf;
            if (!status.zero_len) begin
                for (int d = 0; d < LANES; d++) begin
                    if (COUNT_BITS'(d) < status.used_axes) begin
                        if (status.sat[d]) begin
                            coord_next[d] = AXIS_BITS'(meta_tail.idx_max
                                                       && len[d] != AXIS_BITS'(1));
                        end else begin
                            coord_next[d] = div_coord[d];
                        end
                    end
                end
            end
        end else begin
            flat_next = lflat_reg[LIN_DELAY-1];
            oob_next  = loob_reg[LIN_DELAY-1];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_flat_out      = m_flat_reg;
    assign m_coord_out_0   = m_coord_reg[0];
    assign m_coord_out_1   = m_coord_reg[1];
    assign m_coord_out_2   = m_coord_reg[2];
    assign m_coord_out_3   = m_coord_reg[3];
    assign m_out_of_bounds = m_oob_reg;

endmodule

// ===== hdl/nd_pic_checker.sv =====
// ----------------------------------------------------------------------------
// nd_pic_checker
// Port-level checks of the pixel index converter, bound to the top level.
// ----------------------------------------------------------------------------
module nd_pic_checker
    import nd_pic_pkg::*;
#(
    parameter int AXIS_BITS  = DEF_AXIS_BITS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [INDEX_BITS-1:0] m_flat_out,
    input logic [AXIS_BITS-1:0]  m_coord_out_0,
    input logic [AXIS_BITS-1:0]  m_coord_out_1,
    input logic [AXIS_BITS-1:0]  m_coord_out_2,
    input logic [AXIS_BITS-1:0]  m_coord_out_3,
    input logic                  m_out_of_bounds
);

    logic coords_nonzero;

    assign coords_nonzero = m_coord_out_0 != '0 || m_coord_out_1 != '0
                         || m_coord_out_2 != '0 || m_coord_out_3 != '0;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flat_out)
                                && $stable(m_out_of_bounds))
        else $error("stalled result changed");

    a_mode_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && coords_nonzero |-> m_flat_out == '0)
        else $error("result carries both a flat index and coordinates");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_shape_busy: assert property (@(posedge aclk)
        $past(!aresetn) && aresetn |-> !s_ready)
        else $error("request taken before strides were derived");

endmodule

bind nd_pixel_index_converter nd_pic_checker #(
    .AXIS_BITS  (AXIS_BITS),
    .INDEX_BITS (INDEX_BITS)
) u_nd_pic_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_flat_out      (m_flat_out),
    .m_coord_out_0   (m_coord_out_0),
    .m_coord_out_1   (m_coord_out_1),
    .m_coord_out_2   (m_coord_out_2),
    .m_coord_out_3   (m_coord_out_3),
    .m_out_of_bounds (m_out_of_bounds)
);
